// File: hw/rtl/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u2u_pkg;

    localparam int CP_W        = 21;
    localparam int UNIT_W      = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CP_W-1:0]   REPL_CP    = 21'h00FFFD;
    localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h010000;
    localparam logic [CP_W-1:0]   MIN_2BYTE  = 21'h000080;
    localparam logic [CP_W-1:0]   MIN_3BYTE  = 21'h000800;
    localparam logic [UNIT_W-1:0] HI_SURR    = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR    = 16'hDC00;

    // Lead classes: open-sequence minimum value selector
    typedef enum logic [1:0] {
        LEAD_NONE  = 2'd0,
        LEAD_TWO   = 2'd1,
        LEAD_THREE = 2'd2,
        LEAD_FOUR  = 2'd3
    } lead_class_t;

    // One decoded character handed from the decoder to the unit emitter
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            rep;
    } cp_evt_t;

endpackage

// File: hw/rtl/u2u_front.sv
// Byte decoder: tracks multi-byte sequences and produces decoded code points.
module u2u_front
    import u2u_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    output logic          evt_valid,
    output cp_evt_t       evt
);

    logic [1:0]      bytes_due_reg,     bytes_due_next;
    logic [CP_W-1:0] partial_point_reg, partial_point_next;
    lead_class_t     lead_class_reg,    lead_class_next;

    logic [CP_W-1:0] shifted;
    logic [CP_W-1:0] min_val;

    always_comb
    begin
        shifted = {partial_point_reg[CP_W-7:0], in_byte[5:0]};
        unique case (lead_class_reg)
            LEAD_TWO:   min_val = MIN_2BYTE;
            LEAD_THREE: min_val = MIN_3BYTE;
            default:    min_val = SUPP_BASE;
        endcase
    end

    always_comb
    begin
        bytes_due_next     = bytes_due_reg;
        partial_point_next = partial_point_reg;
        lead_class_next    = lead_class_reg;
        evt_valid          = 1'b0;
        evt.cp             = REPL_CP;
        evt.rep            = 1'b1;
        if (accept)
        begin
            if (bytes_due_reg == 2'd0)
            begin
                if (in_byte == 8'h00)
                begin
                    // terminator: nothing out
                end
                else if (in_byte[7] == 1'b0)
                begin
                    evt_valid = 1'b1;
                    evt.cp    = {{(CP_W-8){1'b0}}, in_byte};
                    evt.rep   = 1'b0;
                end
                else if (in_byte[6] == 1'b0)
                begin
                    evt_valid = 1'b1;   // stray continuation
                end
                else if (in_byte[5] == 1'b0)
                begin
                    partial_point_next = {{(CP_W-5){1'b0}}, in_byte[4:0]};
                    bytes_due_next     = 2'd1;
                    lead_class_next    = LEAD_TWO;
                end
                else if (in_byte[4] == 1'b0)
                begin
                    partial_point_next = {{(CP_W-4){1'b0}}, in_byte[3:0]};
                    bytes_due_next     = 2'd2;
                    lead_class_next    = LEAD_THREE;
                end
                else
                begin
                    // F0-FF, wide leads keep the low three bits
                    partial_point_next = {{(CP_W-3){1'b0}}, in_byte[2:0]};
                    bytes_due_next     = 2'd3;
                    lead_class_next    = LEAD_FOUR;
                end
            end
            else if (in_byte[7:6] != 2'b10)
            begin
                // bad continuation is consumed and closes the sequence
                evt_valid          = 1'b1;
                bytes_due_next     = 2'd0;
                partial_point_next = '0;
                lead_class_next    = LEAD_NONE;
            end
            else if (bytes_due_reg != 2'd1)
            begin
                partial_point_next = shifted;
                bytes_due_next     = bytes_due_reg - 2'd1;
            end
            else
            begin
                evt_valid          = 1'b1;
                bytes_due_next     = 2'd0;
                partial_point_next = '0;
                lead_class_next    = LEAD_NONE;
                if (shifted >= min_val)
                begin
                    evt.cp  = shifted;
                    evt.rep = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_due_reg     <= 2'd0;
            partial_point_reg <= '0;
            lead_class_reg    <= LEAD_NONE;
        end
        else
        begin
            bytes_due_reg     <= bytes_due_next;
            partial_point_reg <= partial_point_next;
            lead_class_reg    <= lead_class_next;
        end
    end

endmodule

// File: hw/rtl/u2u_queue.sv
// Short queue of decoded code points between decoder and unit emitter.
module u2u_queue
    import u2u_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  cp_evt_t wr_data,
    input  logic    rd_en,
    output cp_evt_t rd_data,
    output logic    full,
    output logic    nonempty
);

    cp_evt_t           slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_data  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slots_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/u2u_back.sv
// Unit emitter: turns queued code points into UTF-16 units in an output register.
module u2u_back
    import u2u_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_nonempty,
    input  cp_evt_t           q_data,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output logic [UNIT_W-1:0] utf16_unit,
    output logic              char_done,
    output logic [CP_W-1:0]   code_point,
    output logic              replaced
);

    logic              out_valid_reg;
    logic              high_sent_reg, high_sent_next;
    logic [UNIT_W-1:0] unit_reg,      unit_next;
    logic              done_reg,      done_next;
    logic [CP_W-1:0]   cp_reg;
    logic              rep_reg;

    logic              load;
    logic              supp;
    logic [CP_W-1:0]   offset;

    assign empty      = !out_valid_reg;
    assign utf16_unit = unit_reg;
    assign char_done  = done_reg;
    assign code_point = cp_reg;
    assign replaced   = rep_reg;

    assign load   = (!out_valid_reg || pop) && q_nonempty;
    assign supp   = (q_data.cp >= SUPP_BASE);
    assign offset = q_data.cp - SUPP_BASE;

    always_comb
    begin
        q_pop          = 1'b0;
        high_sent_next = high_sent_reg;
        unit_next      = q_data.cp[UNIT_W-1:0];
        done_next      = 1'b1;
        if (load)
        begin
            if (!supp)
            begin
                q_pop = 1'b1;
            end
            else if (!high_sent_reg)
            begin
                unit_next      = HI_SURR | {6'd0, offset[19:10]};
                done_next      = 1'b0;
                high_sent_next = 1'b1;
            end
            else
            begin
                // second half of the pair retires the queue entry
                unit_next      = LO_SURR | {6'd0, offset[9:0]};
                q_pop          = 1'b1;
                high_sent_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            high_sent_reg <= 1'b0;
        end
        else
        begin
            high_sent_reg <= high_sent_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit_reg <= unit_next;
            done_reg <= done_next;
            cp_reg   <= q_data.cp;
            rep_reg  <= q_data.rep;
        end
    end

endmodule

// File: hw/rtl/utf8_to_utf16_transcoder_core.sv
// UTF-8 to UTF-16 transcoder, top level.
// Takes one UTF-8 byte per transaction and delivers UTF-16 code units, each with
// the decoded code point, a last-unit flag and a replacement flag. A byte is
// taken every cycle while full is low; the decoder sends finished characters
// into a four-entry queue, and the unit emitter drains it at one unit per cycle
// while its output is empty or popped; a supplementary character (a surrogate
// pair) goes out as two units. With nothing ahead, a character enters the queue
// at the edge that accepts its final byte; its first unit then loads into the
// output register. A zero byte between characters ends a string, producing no unit;
// stray or bad continuations and overlong forms yield U+FFFD with replaced set.
module utf8_to_utf16_transcoder_core
    import u2u_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        in_byte,
    input  logic              pop,
    output logic              empty,
    output logic [UNIT_W-1:0] utf16_unit,
    output logic              char_done,
    output logic [CP_W-1:0]   code_point,
    output logic              replaced
);

    logic    accept;
    logic    evt_valid;
    cp_evt_t evt;
    cp_evt_t q_data;
    logic    q_nonempty;
    logic    q_pop;

    assign accept = push && !full;

    u2u_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    u2u_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (evt_valid),
        .wr_data  (evt),
        .rd_en    (q_pop),
        .rd_data  (q_data),
        .full     (full),
        .nonempty (q_nonempty)
    );

    u2u_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .utf16_unit (utf16_unit),
        .char_done  (char_done),
        .code_point (code_point),
        .replaced   (replaced)
    );

endmodule
